[design/vlbp_pkg.sv]
`default_nettype none

package vlbp_pkg;

	localparam int WORD_BITS = 64;
	localparam logic [6:0] MAX_LEN = 7'd64;
	localparam int unsigned CLOSE_BITS = 133;
	localparam logic [63:0] ALL_ONES = '1;
	localparam logic [63:0] END_NIBBLE = 64'h0F;
	localparam logic [6:0] END_NIBBLE_LEN = 7'd4;
	localparam logic [6:0] END_ZERO_LEN = 7'd1;
	localparam int IN_W = 80;
	localparam int OUT_W = 88;

	typedef enum logic [1:0] {
		CMD_APPEND    = 2'd0,
		CMD_CLOSE     = 2'd1,
		CMD_READ      = 2'd2,
		CMD_READ_ONES = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MODE  = 2'd1,
		ST_FULL  = 2'd2,
		ST_SHORT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CL_ONES1,
		S_CL_ONES2,
		S_CL_ZERO,
		S_CL_FLUSH,
		S_RD_WAIT,
		S_RUZ,
		S_RESULT
	} state_t;

	// one append step: new partial word, and the finished word if one closed
	typedef struct packed {
		logic [63:0] partial;
		logic [63:0] word;
		logic        word_done;
	} pack_res_t;

endpackage

`default_nettype wire

[design/vlbp_pack.sv]
`default_nettype none

// Appends len bits of value to the partial word, MSB first.
module vlbp_pack (
	input  logic [63:0]         partial,
	input  logic [5:0]          fill,
	input  logic [63:0]         value,
	input  logic [6:0]          len,
	output vlbp_pkg::pack_res_t res
);
	import vlbp_pkg::*;

	logic [63:0] vm;
	logic [63:0] hi;
	logic [6:0]  sum;
	logic [6:0]  take;
	logic [6:0]  rest;

	always_comb begin
		vm   = value & ~(ALL_ONES << len);
		sum  = {1'b0, fill} + len;
		take = 7'd64 - {1'b0, fill};
		rest = len - take;
		hi   = vm >> rest;
		res.word = (fill == 6'd0) ? hi : ((partial << take) | hi);
		if (!sum[6]) begin
			res.word_done = 1'b0;
			res.partial   = (len == 7'd0) ? partial : ((partial << len) | vm);
		end else begin
			res.word_done = 1'b1;
			res.partial   = (rest == 7'd0) ? 64'd0 : (vm & ~(ALL_ONES << rest));
		end
	end

endmodule

`default_nettype wire

[design/variable_length_bit_packer_unpacker.sv]
// Channel | Dir | Handshake            | Beat layout (low bit first)
// s_axis  | in  | tvalid/tready        | cmd[1:0], data_in[65:2], length[72:66], zero pad
// m_axis  | out | tvalid/tready        | data_out[63:0], status[65:64], bits_left[82:66], pad
//
// One command at a time. Append packs the field as the command is accepted.
// A field read uses the word store's registered read of two adjacent words.
// Close packs the end marker step by step, writing each word that fills, then
// flushes any partly filled last word. Read-ones scans the window bit-serially
// and takes at most 64 bits. m_axis back-pressure holds the result register.
// Reset clears the counters and mode; the word store keeps its contents.
`default_nettype none

module variable_length_bit_packer_unpacker #(
	parameter int STORE_WORDS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// cmd, data_in, length; zero pad
	input  logic [vlbp_pkg::IN_W-1:0] s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// data_out, status, bits_left; zero pad
	output logic [vlbp_pkg::OUT_W-1:0] m_axis_tdata
);
	import vlbp_pkg::*;

	localparam int AW = $clog2(STORE_WORDS);
	localparam int IW = $clog2(STORE_WORDS + 1);
	localparam int unsigned CAP = STORE_WORDS * WORD_BITS;
	localparam int TW = $clog2(CAP + 1);
	localparam logic [IW-1:0] DEPTH_I = IW'(STORE_WORDS);
	localparam logic [IW:0] DEPTH_X = (IW + 1)'(STORE_WORDS);
	localparam logic [TW-1:0] CAP_T = TW'(CAP);
	localparam logic [TW-1:0] CLOSE_T = TW'(CLOSE_BITS);

	// word store
	logic [63:0] store_q [STORE_WORDS];

	// control state
	state_t        state_q, state_d;
	logic [IW-1:0] write_index_q;
	logic [IW-1:0] read_index_q;
	logic [63:0]   partial_q;
	logic [TW-1:0] bit_total_q;
	logic [5:0]    read_offset_q;
	logic          read_mode_q;
	logic          out_valid_q;

	// payload
	logic [6:0]  len_q;
	logic        is_ruz_q;
	logic [63:0] win_q;
	logic [6:0]  k_q;
	logic [63:0] acc_q;
	status_t     status_q;
	logic [63:0] rd0_s1, rd1_s1;
	logic        rd0_ok_s1, rd1_ok_s1;
	logic [63:0] out_data_q;
	status_t     out_status_q;
	logic [16:0] out_left_q;

	// input beat fields
	cmd_t        cmd;
	logic [63:0] data_in;
	logic [6:0]  length_in;
	logic [6:0]  len_c;
	logic        fire;
	logic [TW-1:0] free_bits;
	status_t     acc_status;
	logic        acc_fail;

	assign cmd       = cmd_t'(s_axis_tdata[1:0]);
	assign data_in   = s_axis_tdata[65:2];
	assign length_in = s_axis_tdata[72:66];
	assign len_c     = (length_in > MAX_LEN) ? MAX_LEN : length_in;
	assign s_axis_tready = (state_q == S_IDLE);
	assign fire      = s_axis_tvalid && s_axis_tready;
	assign free_bits = CAP_T - bit_total_q;

	// command checks at accept
	always_comb begin
		acc_status = ST_OK;
		unique case (cmd)
			CMD_APPEND: begin
				if (read_mode_q) acc_status = ST_MODE;
				else if (TW'(len_c) > free_bits) acc_status = ST_FULL;
			end
			CMD_CLOSE: begin
				if (read_mode_q) acc_status = ST_MODE;
				else if (CLOSE_T > free_bits) acc_status = ST_FULL;
			end
			CMD_READ: begin
				if (!read_mode_q) acc_status = ST_MODE;
				else if (TW'(len_c) > bit_total_q) acc_status = ST_SHORT;
			end
			CMD_READ_ONES: begin
				if (!read_mode_q) acc_status = ST_MODE;
			end
			default: acc_status = ST_OK;
		endcase
		acc_fail = (acc_status != ST_OK);
	end

	// read window from two adjacent words
	logic [127:0] cat;
	logic [127:0] cat_shl;
	logic [127:0] cat_shr;
	logic [7:0]   fld_sh;
	logic [63:0]  window;
	logic [63:0]  field_res;

	always_comb begin
		cat       = {rd0_ok_s1 ? rd0_s1 : 64'd0, rd1_ok_s1 ? rd1_s1 : 64'd0};
		cat_shl   = cat << read_offset_q;
		window    = cat_shl[127:64];
		fld_sh    = 8'd128 - {2'b00, read_offset_q} - {1'b0, len_q};
		cat_shr   = cat >> fld_sh;
		field_res = cat_shr[63:0] & ~(ALL_ONES << len_q);
	end

	// read-ones scan step
	logic        ruz_stop, ruz_ok;
	logic [6:0]  ruz_k;
	logic [63:0] ruz_acc;

	always_comb begin
		ruz_stop = 1'b0;
		ruz_ok   = 1'b0;
		ruz_k    = k_q;
		ruz_acc  = acc_q;
		if (k_q == len_q) begin
			ruz_stop = 1'b1;
			ruz_ok   = 1'b1;
		end else if (TW'(k_q) >= bit_total_q) begin
			ruz_stop = 1'b1;
		end else if (!win_q[63]) begin
			ruz_stop = 1'b1;
			ruz_ok   = 1'b1;
			ruz_k    = k_q + 7'd1;
			ruz_acc  = {acc_q[62:0], 1'b0};
		end
	end

	logic res_load;
	assign res_load = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					if (acc_fail) state_d = S_RESULT;
					else begin
						unique case (cmd) inside
							CMD_APPEND:                   state_d = S_RESULT;
							CMD_CLOSE:                    state_d = S_CL_ONES1;
							CMD_READ, CMD_READ_ONES:      state_d = S_RD_WAIT;
							default:                      state_d = S_RESULT;
						endcase
					end
				end
			end
			S_CL_ONES1: state_d = S_CL_ONES2;
			S_CL_ONES2: state_d = S_CL_ZERO;
			S_CL_ZERO:  state_d = S_CL_FLUSH;
			S_CL_FLUSH: state_d = S_RESULT;
			S_RD_WAIT:  state_d = is_ruz_q ? S_RUZ : S_RESULT;
			S_RUZ:      if (ruz_stop) state_d = S_RESULT;
			S_RESULT:   if (res_load) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// datapath controls
	logic        pk_en;
	logic [63:0] pk_v;
	logic [6:0]  pk_len;
	pack_res_t   pk;
	logic        flush_en;
	logic        adv_en;
	logic [6:0]  adv_n;
	logic        mem_we;
	logic [63:0] mem_wdata;

	always_comb begin
		pk_en    = 1'b0;
		pk_v     = data_in;
		pk_len   = len_c;
		flush_en = 1'b0;
		adv_en   = 1'b0;
		adv_n    = len_q;
		unique case (state_q) inside
			S_IDLE: begin
				pk_en = fire && !acc_fail && (cmd == CMD_APPEND || cmd == CMD_CLOSE);
				if (cmd == CMD_CLOSE) begin
					pk_v   = END_NIBBLE;
					pk_len = END_NIBBLE_LEN;
				end
			end
			S_CL_ONES1, S_CL_ONES2: begin
				pk_en  = 1'b1;
				pk_v   = ALL_ONES;
				pk_len = MAX_LEN;
			end
			S_CL_ZERO: begin
				pk_en  = 1'b1;
				pk_v   = 64'd0;
				pk_len = END_ZERO_LEN;
			end
			S_CL_FLUSH: flush_en = (bit_total_q[5:0] != 6'd0);
			S_RD_WAIT:  adv_en = !is_ruz_q;
			S_RUZ: begin
				adv_en = ruz_stop && ruz_ok;
				adv_n  = ruz_k;
			end
			S_RESULT: adv_en = 1'b0;
			default:  adv_en = 1'b0;
		endcase
		mem_we    = ((pk_en && pk.word_done) || flush_en) && (write_index_q < DEPTH_I);
		mem_wdata = flush_en ? (partial_q << (7'd64 - {1'b0, bit_total_q[5:0]})) : pk.word;
	end

	vlbp_pack u_pack (
		.partial (partial_q),
		.fill    (bit_total_q[5:0]),
		.value   (pk_v),
		.len     (pk_len),
		.res     (pk)
	);

	logic [6:0]    adv_off;
	logic [IW:0]   rd1_idx;
	assign adv_off = {1'b0, read_offset_q} + adv_n;
	assign rd1_idx = {1'b0, read_index_q} + {{IW{1'b0}}, 1'b1};

	// store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) store_q[write_index_q[AW-1:0]] <= mem_wdata;
		rd0_s1    <= store_q[read_index_q[AW-1:0]];
		rd1_s1    <= store_q[rd1_idx[AW-1:0]];
		rd0_ok_s1 <= (read_index_q < DEPTH_I);
		rd1_ok_s1 <= (rd1_idx < DEPTH_X);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			write_index_q <= '0;
			read_index_q  <= '0;
			partial_q     <= '0;
			bit_total_q   <= '0;
			read_offset_q <= '0;
			read_mode_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pk_en) begin
				partial_q   <= pk.partial;
				bit_total_q <= bit_total_q + TW'(pk_len);
				if (pk.word_done) write_index_q <= write_index_q + IW'(1);
			end
			if (state_q == S_CL_FLUSH) begin
				partial_q     <= '0;
				read_mode_q   <= 1'b1;
				read_index_q  <= '0;
				read_offset_q <= '0;
			end
			if (adv_en) begin
				read_index_q  <= read_index_q + IW'(adv_off[6]);
				read_offset_q <= adv_off[5:0];
				bit_total_q   <= bit_total_q - TW'(adv_n);
			end
			if (res_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					len_q    <= (cmd == CMD_READ_ONES && len_c == 7'd0) ? 7'd1 : len_c;
					is_ruz_q <= (cmd == CMD_READ_ONES);
					acc_q    <= '0;
					k_q      <= '0;
					status_q <= acc_status;
				end
			end
			S_RD_WAIT: begin
				if (is_ruz_q) win_q <= window;
				else acc_q <= field_res;
			end
			S_RUZ: begin
				if (!ruz_stop) begin
					acc_q <= {acc_q[62:0], 1'b1};
					k_q   <= k_q + 7'd1;
					win_q <= {win_q[62:0], 1'b0};
				end else if (ruz_ok) begin
					acc_q <= ruz_acc;
				end else begin
					acc_q    <= '0;
					status_q <= ST_SHORT;
				end
			end
			default: ;
		endcase
		if (res_load) begin
			out_data_q   <= acc_q;
			out_status_q <= status_q;
			out_left_q   <= 17'(bit_total_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_left_q, out_status_q, out_data_q};

	// no store writes once the stream is closed
	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		read_mode_q |-> !mem_we)
		else $error("store write in read mode");

	a_total_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		bit_total_q <= CAP_T)
		else $error("bit count beyond capacity");

	// a rejected command leaves the stream untouched
	a_fail_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && acc_fail) |=> ($stable(bit_total_q) && $stable(read_index_q)
			&& $stable(read_mode_q) && $stable(write_index_q)))
		else $error("rejected command changed state");

	a_scan_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUZ) |-> (k_q <= len_q))
		else $error("scan past its limit");

	a_read_covered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_WAIT && !is_ruz_q) |-> (TW'(len_q) <= bit_total_q))
		else $error("field read beyond held bits");

endmodule

`default_nettype wire

[bench/variable_length_bit_packer_unpacker_tb.sv]
module variable_length_bit_packer_unpacker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vlbp_pkg::*;

	// Half-size store: one full fill, close and drain fits a run of the usual length.
	// Reset comes only once and nothing leaves read mode, so the run is a single write
	// phase, one close and one read phase.
	localparam int unsigned STORE_WORDS   = 512;
	localparam int unsigned CAPACITY      = STORE_WORDS * 64;
	localparam int unsigned DATA_ROOM     = CAPACITY - CLOSE_BITS;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned REPLY_SLOTS   = 64;
	localparam int unsigned FIELD_SLOTS   = 8192;

	// One result beat.
	typedef struct packed {
		logic [63:0] data_out;
		status_t     status;
		logic [16:0] bits_left;
	} reply_t;

	// A field as it was appended. A run is k ones and then a single zero.
	typedef struct {
		bit         is_run;
		logic [6:0] len_code;
	} field_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tready;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	variable_length_bit_packer_unpacker #(
		.STORE_WORDS(STORE_WORDS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// ---------------------------------------------------------------
	// Bit stream predictor: own copy of the store and its counters.
	// ---------------------------------------------------------------
	logic [63:0] stream_words [STORE_WORDS];
	int unsigned wr_idx = 0;        // complete words written
	int unsigned rd_idx = 0;        // word holding the next bit to read
	int unsigned rd_off = 0;        // bit position inside that word, MSB = 0
	logic [63:0] part_word = '0;    // word being filled, right aligned
	int unsigned held_bits = 0;
	bit in_read_mode = 1'b0;

	// expected replies, oldest at reply_rd
	reply_t replies_due [REPLY_SLOTS];
	int unsigned reply_wr = 0;
	int unsigned reply_rd = 0;
	// appended fields, oldest at field_rd
	field_rec_t written_fields [FIELD_SLOTS];
	int unsigned field_wr = 0;
	int unsigned field_rd = 0;
	int unsigned error_count = 0;
	int unsigned beats_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned stall_left = 0;
	logic [15:0] stall_pattern = '1;
	reply_t front_reply;

	// past the last word reads as zero
	function automatic logic [63:0] stream_word_at(input int unsigned idx);
		return (idx < STORE_WORDS) ? stream_words[idx] : '0;
	endfunction

	// append n bits of v, MSB first; caller has checked the room
	function automatic void stream_put(input logic [63:0] v, input int unsigned n);
		int unsigned fill;
		int unsigned take;
		int unsigned rest;
		logic [63:0] hi;
		logic [63:0] w;
		fill = held_bits & 63;
		if (n < 64)
			v &= ~(ALL_ONES << n);
		if (fill + n < 64) begin
			if (n != 0)
				part_word = (part_word << n) | v;
		end else begin
			// word closes: top bits of v finish it, the rest starts the next one
			take = 64 - fill;
			rest = n - take;
			hi = v >> rest;
			w = (fill == 0) ? hi : ((part_word << take) | hi);
			if (wr_idx < STORE_WORDS)
				stream_words[wr_idx] = w;
			wr_idx++;
			part_word = (rest == 0) ? '0 : (v & ~(ALL_ONES << rest));
		end
		held_bits += n;
	endfunction

	function automatic void stream_skip(input int unsigned n);
		int unsigned off;
		off = rd_off + n;
		rd_idx += off >> 6;
		rd_off = off & 63;
		held_bits -= n;
	endfunction

	// expected reply for one accepted command; updates the predictor state
	function automatic reply_t bitstream_step(input cmd_t c, input logic [63:0] d,
			input logic [6:0] l);
		int unsigned n;
		int unsigned lim;
		int unsigned k;
		int unsigned pos;
		int unsigned off;
		int unsigned n2;
		int unsigned fill;
		logic [63:0] acc;
		logic [63:0] w0;
		logic b;
		bit done;
		reply_t r;
		n = (l > MAX_LEN) ? 64 : 32'(l);
		r.data_out = '0;
		r.status = ST_OK;
		case (c)
			CMD_APPEND: begin
				if (in_read_mode)
					r.status = ST_MODE;
				else if (n > CAPACITY - held_bits)
					r.status = ST_FULL;
				else
					stream_put(d, n);
			end
			CMD_CLOSE: begin
				if (in_read_mode)
					r.status = ST_MODE;
				else if (CLOSE_BITS > CAPACITY - held_bits)
					r.status = ST_FULL;
				else begin
					// end marker: 4 + 128 ones, one zero; last word zero padded
					stream_put(END_NIBBLE, 32'(END_NIBBLE_LEN));
					stream_put(ALL_ONES, 64);
					stream_put(ALL_ONES, 64);
					stream_put('0, 32'(END_ZERO_LEN));
					fill = held_bits & 63;
					if (fill != 0 && wr_idx < STORE_WORDS)
						stream_words[wr_idx] = part_word << (64 - fill);
					part_word = '0;
					in_read_mode = 1'b1;
					rd_idx = 0;
					rd_off = 0;
				end
			end
			CMD_READ: begin
				if (!in_read_mode)
					r.status = ST_MODE;
				else if (n > held_bits)
					r.status = ST_SHORT;
				else if (n > 0) begin
					off = rd_off;
					w0 = stream_word_at(rd_idx) << off;
					r.data_out = w0 >> (64 - n);
					// field crosses into the next word
					if (off + n > 64) begin
						n2 = off + n - 64;
						r.data_out |= stream_word_at(rd_idx + 1) >> (64 - n2);
					end
					stream_skip(n);
				end
			end
			default: begin
				if (!in_read_mode)
					r.status = ST_MODE;
				else begin
					// bit by bit until a zero, the limit, or the end of the stream
					lim = (n == 0) ? 1 : n;
					k = 0;
					acc = '0;
					done = 1'b0;
					while (k < lim && k < held_bits && !done) begin
						pos = rd_off + k;
						w0 = stream_word_at(rd_idx + (pos >> 6));
						b = w0[63 - (pos & 63)];
						acc = {acc[62:0], b};
						k++;
						if (!b)
							done = 1'b1;
					end
					if (k == lim)
						done = 1'b1;
					if (!done)
						r.status = ST_SHORT;
					else begin
						r.data_out = acc;
						stream_skip(k);
					end
				end
			end
		endcase
		r.bits_left = 17'(held_bits);
		return r;
	endfunction

	function automatic logic [63:0] field_bits();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void note_field(input bit run, input logic [6:0] l);
		written_fields[field_wr] = '{is_run: run, len_code: l};
		field_wr++;
	endfunction

	// ---------------------------------------------------------------
	// Sender: bursts of random length, random gaps between bursts.
	// Inputs change on the falling edge.
	// ---------------------------------------------------------------
	task automatic send_cmd(input cmd_t c, input logic [63:0] d, input logic [6:0] l);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, l, d, c};
		do
			@(posedge clk);
		while (!s_axis_tready);
		replies_due[reply_wr % REPLY_SLOTS] = bitstream_step(c, d, l);
		reply_wr++;
	endtask

	task automatic append_field(input logic [63:0] d, input logic [6:0] l);
		send_cmd(CMD_APPEND, d, l);
		note_field(1'b0, l);
	endtask

	// k ones, then a zero whose data word has garbage above bit 0
	task automatic append_run(input logic [6:0] k);
		if (k != 0)
			send_cmd(CMD_APPEND, ALL_ONES, k);
		send_cmd(CMD_APPEND, {$urandom, $urandom} & ~64'd1, 7'd1);
		note_field(1'b1, k);
	endtask

	// ---------------------------------------------------------------
	// Receiver: 16-bit stall pattern rotated every cycle, reloaded
	// when stall_left runs out; a quarter of the patterns never stall.
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = 128;
			stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
			if (stall_pattern == '0)
				stall_pattern = 16'h0001;
		end
		stall_left--;
		stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
		m_axis_tready <= stall_pattern[0];
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] beat %0d: %s", $realtime, beats_seen, what);
		error_count++;
	endtask

	// result check, oldest expectation first
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (reply_rd == reply_wr)
				report_mismatch("result beat with nothing expected");
			else begin
				front_reply = replies_due[reply_rd % REPLY_SLOTS];
				reply_rd++;
				if (m_axis_tdata[63:0] !== front_reply.data_out)
					report_mismatch($sformatf("data_out %h, want %h",
						m_axis_tdata[63:0], front_reply.data_out));
				if (m_axis_tdata[65:64] !== front_reply.status)
					report_mismatch($sformatf("status %0d, want %0d",
						m_axis_tdata[65:64], front_reply.status));
				if (m_axis_tdata[82:66] !== front_reply.bits_left)
					report_mismatch($sformatf("bits_left %0d, want %0d",
						m_axis_tdata[82:66], front_reply.bits_left));
			end
			beats_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("variable_length_bit_packer_unpacker_tb: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reads before the close are refused
	task automatic test_reads_in_write_mode();
		send_cmd(CMD_READ, '1, 7'd64);
		send_cmd(CMD_READ_ONES, '0, 7'd0);
		send_cmd(CMD_READ, 64'h5, 7'd0);
		send_cmd(CMD_READ_ONES, '1, 7'd127);
	endtask

	// length extremes, clamping above 64, masking of bits above the length
	task automatic test_append_edges();
		append_field('1, 7'd0);
		append_field('1, 7'd1);
		append_field('1, 7'd64);
		append_field('0, 7'd64);
		append_field(64'hA5A5_5A5A_F00F_0FF0, 7'd127);
		append_field(64'h8000_0000_0000_0001, 7'd65);
		append_field('1, 7'd7);
		append_field(64'h0123_4567_89AB_CDEF, 7'd33);
		append_field({$urandom, $urandom}, 7'd63);
		append_run(7'd64);
		append_run(7'd0);
		append_run(7'd5);
	endtask

	// random fields and runs, with the odd refused read mixed in
	task automatic test_random_appends();
		int unsigned pick;
		while (held_bits + 200 < DATA_ROOM) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				send_cmd(CMD_READ, field_bits(), 7'($urandom));
			else if (pick < 5)
				send_cmd(CMD_READ_ONES, field_bits(), 7'($urandom));
			else if (pick < 30)
				append_run(7'($urandom_range(0, 64)));
			else if (pick < 60)
				append_field(field_bits(), 7'($urandom_range(64, 127)));
			else
				append_field(field_bits(), 7'($urandom_range(0, 63)));
		end
	endtask

	// Top up to exactly the room the end marker needs, so the close brings the
	// stream to full capacity. A full store would lock out the close for good.
	task automatic test_fill_and_close();
		while (DATA_ROOM - held_bits >= 64)
			append_field(field_bits(), 7'd64);
		append_field(field_bits(), 7'(DATA_ROOM - held_bits));
		send_cmd(CMD_CLOSE, field_bits(), 7'($urandom));
		send_cmd(CMD_CLOSE, '0, 7'd0);
		send_cmd(CMD_APPEND, '1, 7'd64);
	endtask

	// read the fields back as written, with refused commands, zero-length reads
	// and the occasional misaligned read in between
	task automatic test_decode_fields();
		int unsigned pick;
		int unsigned k;
		field_rec_t f;
		while (field_rd != field_wr) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				send_cmd(CMD_APPEND, field_bits(), 7'($urandom));
			else if (pick < 3)
				send_cmd(CMD_CLOSE, field_bits(), 7'($urandom));
			else if (pick < 6)
				send_cmd(CMD_READ, field_bits(), 7'd0);
			else if (pick < 8)
				send_cmd(CMD_READ, field_bits(), 7'($urandom_range(1, 127)));
			else begin
				f = written_fields[field_rd];
				field_rd++;
				k = 32'(f.len_code);
				if (!f.is_run)
					send_cmd(CMD_READ, field_bits(), f.len_code);
				else if (k == 0)
					// limit zero acts as one bit
					send_cmd(CMD_READ_ONES, field_bits(),
						($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(1, 127)));
				else if (k == 64 || $urandom_range(0, 3) == 0) begin
					// stop on the limit with all ones, then pick up the zero
					send_cmd(CMD_READ_ONES, field_bits(),
						(k == 64) ? 7'($urandom_range(64, 127)) : f.len_code);
					send_cmd(CMD_READ_ONES, field_bits(), 7'($urandom_range(0, 1)));
				end else
					send_cmd(CMD_READ_ONES, field_bits(), 7'($urandom_range(k + 1, 127)));
			end
		end
	endtask

	// through the end marker to an empty stream, then reads on it, all short but the zero-length field read
	task automatic test_drain_to_empty();
		int unsigned pick;
		while (held_bits != 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				send_cmd(CMD_READ_ONES, field_bits(), 7'($urandom));
			else if (pick < 45 && held_bits < 64)
				send_cmd(CMD_READ, field_bits(), 7'($urandom_range(held_bits + 1, 64)));
			else
				send_cmd(CMD_READ, field_bits(),
					7'($urandom_range(1, (held_bits < 64) ? held_bits : 64)));
		end
		send_cmd(CMD_READ, field_bits(), 7'd1);
		send_cmd(CMD_READ, field_bits(), 7'd0);
		send_cmd(CMD_READ_ONES, field_bits(), 7'd0);
		send_cmd(CMD_READ_ONES, field_bits(), 7'd127);
		send_cmd(CMD_READ, field_bits(), 7'd127);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reads_in_write_mode();
		test_append_edges();
		test_random_appends();
		test_fill_and_close();
		test_decode_fields();
		test_drain_to_empty();

		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (reply_rd != reply_wr)
			@(posedge clk);
		// a stray beat would show up within the longest scan
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("variable_length_bit_packer_unpacker_tb: clean");
		else
			$display("variable_length_bit_packer_unpacker_tb: errors");
		$finish;
	end

endmodule

[variable_length_bit_packer_unpacker.f]
design/vlbp_pkg.sv
design/vlbp_pack.sv
design/variable_length_bit_packer_unpacker.sv
bench/variable_length_bit_packer_unpacker_tb.sv
